@@ hw/rtl/pcsp_pkg.sv @@
// Shared types and constants for the printf conversion spec parser.
// Character codes, length codes, run modes and the parser control record.
// No dependencies.
`default_nettype none

package pcsp_pkg;

   localparam int NUMBER_BITS_DEFAULT = 31;

   localparam int CHAR_W   = 8;
   localparam int STAR_W   = 32;
   localparam int FIELD_W  = 31;
   localparam int LENGTH_W = 3;
   localparam int FLAG_W   = 5;

   // flag bit positions
   localparam int FLAG_MINUS = 0;
   localparam int FLAG_PLUS  = 1;
   localparam int FLAG_SPACE = 2;
   localparam int FLAG_HASH  = 3;
   localparam int FLAG_ZERO  = 4;

   // characters of interest
   localparam logic [CHAR_W-1:0] CHR_PERCENT = 8'h25;
   localparam logic [CHAR_W-1:0] CHR_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHR_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CHR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHR_HASH    = 8'h23;
   localparam logic [CHAR_W-1:0] CHR_DOT     = 8'h2E;
   localparam logic [CHAR_W-1:0] CHR_STAR    = 8'h2A;
   localparam logic [CHAR_W-1:0] CHR_LOWER_H = 8'h68;
   localparam logic [CHAR_W-1:0] CHR_LOWER_L = 8'h6C;
   localparam logic [CHAR_W-1:0] CHR_UPPER_L = 8'h4C;
   localparam logic [CHAR_W-1:0] CHR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHR_NINE    = 8'h39;

   // length modifier codes
   localparam logic [LENGTH_W-1:0] LEN_NONE    = 3'd0;
   localparam logic [LENGTH_W-1:0] LEN_H       = 3'd1;
   localparam logic [LENGTH_W-1:0] LEN_HH      = 3'd2;
   localparam logic [LENGTH_W-1:0] LEN_L       = 3'd3;
   localparam logic [LENGTH_W-1:0] LEN_LL      = 3'd4;
   localparam logic [LENGTH_W-1:0] LEN_UPPER_L = 3'd5;

   typedef enum logic [3:0] {
      RUN_NONE  = 4'b0001,
      RUN_WZERO = 4'b0010,
      RUN_WIDTH = 4'b0100,
      RUN_PREC  = 4'b1000
   } pcsp_run_type;

   typedef struct packed {
      logic [FLAG_W-1:0]   flags;
      logic                prec_seen;
      logic [LENGTH_W-1:0] length;
      logic [CHAR_W-1:0]   prev_char;
      pcsp_run_type        run;
      logic                overflow;
   } pcsp_ctrl_type;

   localparam pcsp_ctrl_type CTRL_RESET = '{
      flags:     '0,
      prec_seen: 1'b0,
      length:    LEN_NONE,
      prev_char: CHR_PERCENT,
      run:       RUN_NONE,
      overflow:  1'b0
   };

endpackage

`default_nettype wire

@@ hw/rtl/pcsp_update.sv @@
// Next-state logic of the parser: applies one character to the parser state.
// Depends on pcsp_pkg.
`default_nettype none

module pcsp_update #(
   parameter int NUMBER_BITS = pcsp_pkg::NUMBER_BITS_DEFAULT
) (
   input  pcsp_pkg::pcsp_ctrl_type         ctrl_cur,
   input  logic [NUMBER_BITS-1:0]          width_cur,
   input  logic [NUMBER_BITS-1:0]          prec_cur,
   input  logic [pcsp_pkg::CHAR_W-1:0]     ch,
   input  logic [pcsp_pkg::STAR_W-1:0]     star_value,
   output pcsp_pkg::pcsp_ctrl_type         ctrl_nxt,
   output logic [NUMBER_BITS-1:0]          width_nxt,
   output logic [NUMBER_BITS-1:0]          prec_nxt
);
   import pcsp_pkg::*;

   localparam int MAC_W = NUMBER_BITS + 4;
   localparam logic [NUMBER_BITS-1:0] NUM_MAX = {NUMBER_BITS{1'b1}};

   logic                   is_digit;
   logic [CHAR_W-1:0]      digit_byte;
   logic [3:0]             digit;
   logic [NUMBER_BITS-1:0] digit_n;
   logic [MAC_W-1:0]       width_mac;
   logic [MAC_W-1:0]       prec_mac;
   logic                   width_mac_sat;
   logic                   prec_mac_sat;
   logic                   star_neg;
   logic [STAR_W-1:0]      star_mag;
   logic                   star_sat;
   logic [NUMBER_BITS-1:0] star_num;
   logic                   after_dot;

   assign is_digit   = (ch >= CHR_ZERO) && (ch <= CHR_NINE);
   assign digit_byte = ch - CHR_ZERO;
   assign digit      = digit_byte[3:0];
   assign digit_n    = NUMBER_BITS'(digit);
   assign after_dot  = (ctrl_cur.prev_char == CHR_DOT);

   // times ten plus digit, saturate when the top nibble is nonzero
   assign width_mac = (MAC_W'(width_cur) << 3) + (MAC_W'(width_cur) << 1) + MAC_W'(digit);
   assign prec_mac  = (MAC_W'(prec_cur) << 3) + (MAC_W'(prec_cur) << 1) + MAC_W'(digit);
   assign width_mac_sat = |width_mac[MAC_W-1:NUMBER_BITS];
   assign prec_mac_sat  = |prec_mac[MAC_W-1:NUMBER_BITS];

   // magnitude of the star argument; the most negative value wraps to 2^31
   assign star_neg = star_value[STAR_W-1];
   assign star_mag = star_neg ? (~star_value + STAR_W'(1)) : star_value;
   assign star_sat = |star_mag[STAR_W-1:NUMBER_BITS];
   assign star_num = star_sat ? NUM_MAX : star_mag[NUMBER_BITS-1:0];

   always_comb begin
      ctrl_nxt           = ctrl_cur;
      width_nxt          = width_cur;
      prec_nxt           = prec_cur;
      ctrl_nxt.prev_char = ch;
      if (is_digit) begin
         unique case (ctrl_cur.run)
            RUN_PREC: begin
               prec_nxt = prec_mac_sat ? NUM_MAX : prec_mac[NUMBER_BITS-1:0];
               if (prec_mac_sat) begin
                  ctrl_nxt.overflow = 1'b1;
               end
            end
            RUN_WIDTH: begin
               width_nxt = width_mac_sat ? NUM_MAX : width_mac[NUMBER_BITS-1:0];
               if (width_mac_sat) begin
                  ctrl_nxt.overflow = 1'b1;
               end
            end
            RUN_NONE: begin
               if (after_dot) begin
                  ctrl_nxt.run       = RUN_PREC;
                  ctrl_nxt.prec_seen = 1'b1;
                  prec_nxt           = digit_n;
               end else if (digit == 4'd0) begin
                  ctrl_nxt.run             = RUN_WZERO;
                  ctrl_nxt.flags[FLAG_ZERO] = 1'b1;
               end else begin
                  ctrl_nxt.run = RUN_WIDTH;
                  width_nxt    = digit_n;
               end
            end
            RUN_WZERO: begin
               if (digit != 4'd0) begin
                  ctrl_nxt.run = RUN_WIDTH;
                  width_nxt    = digit_n;
               end
            end
            default: begin
               ctrl_nxt.run = RUN_NONE;
            end
         endcase
      end else begin
         ctrl_nxt.run = RUN_NONE;
         unique case (ch)
            CHR_MINUS: ctrl_nxt.flags[FLAG_MINUS] = 1'b1;
            CHR_PLUS:  ctrl_nxt.flags[FLAG_PLUS]  = 1'b1;
            CHR_SPACE: ctrl_nxt.flags[FLAG_SPACE] = 1'b1;
            CHR_HASH:  ctrl_nxt.flags[FLAG_HASH]  = 1'b1;
            CHR_DOT: begin
               prec_nxt           = '0;
               ctrl_nxt.prec_seen = 1'b1;
            end
            CHR_STAR: begin
               if (after_dot) begin
                  ctrl_nxt.prec_seen = !star_neg;
                  prec_nxt           = star_neg ? '0 : star_num;
                  if (!star_neg && star_sat) begin
                     ctrl_nxt.overflow = 1'b1;
                  end
               end else begin
                  width_nxt = star_num;
                  if (star_neg) begin
                     ctrl_nxt.flags[FLAG_MINUS] = 1'b1;
                  end
                  if (star_sat) begin
                     ctrl_nxt.overflow = 1'b1;
                  end
               end
            end
            CHR_LOWER_H: ctrl_nxt.length =
               (ctrl_cur.prev_char == CHR_LOWER_H) ? LEN_HH : LEN_H;
            CHR_LOWER_L: ctrl_nxt.length =
               (ctrl_cur.prev_char == CHR_LOWER_L) ? LEN_LL : LEN_L;
            CHR_UPPER_L: ctrl_nxt.length = LEN_UPPER_L;
            default: begin
               ctrl_nxt.run = RUN_NONE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/pcsp_rsp_reg.sv @@
// Result register of the parser: holds one finished spec until it is taken.
// Depends on pcsp_pkg.
`default_nettype none

module pcsp_rsp_reg #(
   parameter int NUMBER_BITS = pcsp_pkg::NUMBER_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  pcsp_pkg::pcsp_ctrl_type           ctrl,
   input  logic [NUMBER_BITS-1:0]            width_num,
   input  logic [NUMBER_BITS-1:0]            prec_num,
   output logic                              free,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_flag_minus,
   output logic                              rsp_flag_plus,
   output logic                              rsp_flag_space,
   output logic                              rsp_flag_hash,
   output logic                              rsp_flag_zero,
   output logic [pcsp_pkg::FIELD_W-1:0]      rsp_field_width,
   output logic [pcsp_pkg::FIELD_W-1:0]      rsp_precision_value,
   output logic                              rsp_precision_given,
   output logic [pcsp_pkg::LENGTH_W-1:0]     rsp_length_code,
   output logic [pcsp_pkg::CHAR_W-1:0]       rsp_specifier,
   output logic                              rsp_overflow
);
   import pcsp_pkg::*;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [FLAG_W-1:0]   flags_ff;
   logic [FIELD_W-1:0]  width_ff;
   logic [FIELD_W-1:0]  prec_ff;
   logic                given_ff;
   logic [LENGTH_W-1:0] length_ff;
   logic [CHAR_W-1:0]   spec_ff;
   logic                overflow_ff;

   assign free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flags_ff    <= ctrl.flags;
         width_ff    <= FIELD_W'(width_num);
         prec_ff     <= ctrl.prec_seen ? FIELD_W'(prec_num) : '0;
         given_ff    <= ctrl.prec_seen;
         length_ff   <= ctrl.length;
         spec_ff     <= ctrl.prev_char;
         overflow_ff <= ctrl.overflow;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_flag_minus      = flags_ff[FLAG_MINUS];
   assign rsp_flag_plus       = flags_ff[FLAG_PLUS];
   assign rsp_flag_space      = flags_ff[FLAG_SPACE];
   assign rsp_flag_hash       = flags_ff[FLAG_HASH];
   assign rsp_flag_zero       = flags_ff[FLAG_ZERO];
   assign rsp_field_width     = width_ff;
   assign rsp_precision_value = prec_ff;
   assign rsp_precision_given = given_ff;
   assign rsp_length_code     = length_ff;
   assign rsp_specifier       = spec_ff;
   assign rsp_overflow        = overflow_ff;

endmodule

`default_nettype wire

@@ hw/rtl/printf_conversion_spec_parser.sv @@
// printf conversion spec parser, top level.
// A request passes the input register, then the result register; the pcsp_update state update is combinational.
// Throughput: one character per cycle unless a last character waits on a full result register.
// Reset (synchronous, active high) empties both registers and returns the parser state
// to the start of a spec; the parser state also returns there after every last character.
// Depends on pcsp_pkg, pcsp_update and pcsp_rsp_reg.
`default_nettype none

module printf_conversion_spec_parser #(
   parameter int NUMBER_BITS = pcsp_pkg::NUMBER_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel: one character per request
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pcsp_pkg::CHAR_W-1:0]       req_ch,
   input  logic signed [pcsp_pkg::STAR_W-1:0] req_star_value,
   input  logic                              req_last,
   // result channel: one result per finished spec
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_flag_minus,
   output logic                              rsp_flag_plus,
   output logic                              rsp_flag_space,
   output logic                              rsp_flag_hash,
   output logic                              rsp_flag_zero,
   output logic [pcsp_pkg::FIELD_W-1:0]      rsp_field_width,
   output logic [pcsp_pkg::FIELD_W-1:0]      rsp_precision_value,
   output logic                              rsp_precision_given,
   output logic [pcsp_pkg::LENGTH_W-1:0]     rsp_length_code,
   output logic [pcsp_pkg::CHAR_W-1:0]       rsp_specifier,
   output logic                              rsp_overflow
);
   import pcsp_pkg::*;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_ch_ff;
   logic [STAR_W-1:0] in_star_ff;
   logic              in_last_ff;

   // parser state
   pcsp_ctrl_type          ctrl_ff, ctrl_in;
   logic [NUMBER_BITS-1:0] width_ff, width_in;
   logic [NUMBER_BITS-1:0] prec_ff, prec_in;

   // next state from the character in the input register
   pcsp_ctrl_type          ctrl_nxt;
   logic [NUMBER_BITS-1:0] width_nxt;
   logic [NUMBER_BITS-1:0] prec_nxt;

   logic rsp_free;
   logic advance;
   logic req_take;
   logic rsp_load;

   // Advance the held character when it produces no result, or when the
   // result register is empty or being emptied in this cycle.
   assign advance   = in_valid_ff && (!in_last_ff || rsp_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = advance && in_last_ff;

   always_comb begin
      in_valid_in = in_valid_ff && !advance;
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold the request payload while it waits
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ch_ff   <= req_ch;
         in_star_ff <= req_star_value;
         in_last_ff <= req_last;
      end
   end

   pcsp_update #(
      .NUMBER_BITS(NUMBER_BITS)
   ) u_update (
      .ctrl_cur  (ctrl_ff),
      .width_cur (width_ff),
      .prec_cur  (prec_ff),
      .ch        (in_ch_ff),
      .star_value(in_star_ff),
      .ctrl_nxt  (ctrl_nxt),
      .width_nxt (width_nxt),
      .prec_nxt  (prec_nxt)
   );

   // Commit the update on advance; drop back to the start of a spec after
   // the last character, whose updated state goes to the result register.
   always_comb begin
      ctrl_in  = ctrl_ff;
      width_in = width_ff;
      prec_in  = prec_ff;
      if (advance) begin
         if (in_last_ff) begin
            ctrl_in  = CTRL_RESET;
            width_in = '0;
            prec_in  = '0;
         end else begin
            ctrl_in  = ctrl_nxt;
            width_in = width_nxt;
            prec_in  = prec_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff  <= CTRL_RESET;
         width_ff <= '0;
         prec_ff  <= '0;
      end else begin
         ctrl_ff  <= ctrl_in;
         width_ff <= width_in;
         prec_ff  <= prec_in;
      end
   end

   pcsp_rsp_reg #(
      .NUMBER_BITS(NUMBER_BITS)
   ) u_rsp_reg (
      .clock              (clock),
      .reset              (reset),
      .load               (rsp_load),
      .ctrl               (ctrl_nxt),
      .width_num          (width_nxt),
      .prec_num           (prec_nxt),
      .free               (rsp_free),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_flag_minus     (rsp_flag_minus),
      .rsp_flag_plus      (rsp_flag_plus),
      .rsp_flag_space     (rsp_flag_space),
      .rsp_flag_hash      (rsp_flag_hash),
      .rsp_flag_zero      (rsp_flag_zero),
      .rsp_field_width    (rsp_field_width),
      .rsp_precision_value(rsp_precision_value),
      .rsp_precision_given(rsp_precision_given),
      .rsp_length_code    (rsp_length_code),
      .rsp_specifier      (rsp_specifier),
      .rsp_overflow       (rsp_overflow)
   );

endmodule

`default_nettype wire
